// File: rtl/core/otl_pkg.sv
// Shared types, codes and defaults of the ordered task list.
package otl_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int POS_W     = 6;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CAT    = 2'd2;
	localparam logic [1:0] OP_PRIO   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADPOS  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	typedef struct packed {
		logic [15:0] task_id;
		logic [7:0]  category;
		logic [7:0]  prio;
	} rec_t;

	typedef struct packed {
		rec_t             rec;
		logic [POS_W-1:0] pos;
		logic [1:0]       status;
		logic             last;
	} res_t;

endpackage

// File: rtl/core/ordered_task_list.sv
// Top level of the ordered task list: record store, sequencer and output register.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | op, category, priority_req, task_id, position
//  out     | out_valid / out_ready| out_task_id, out_category, out_priority,
//          |                      | match_position, status, last
//
// One item is worked on at a time; the next item is accepted as soon as the final
// result of the current one has moved into the output register. A remove and a search
// read the records one after another, since the single read port of the record store
// delivers one record per cycle. A stalled output holds the search scan in place.
// Reset clears the record count and the control state; the record store itself is not
// cleared.
module ordered_task_list #(
	parameter int DEPTH = otl_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  category,
	input  logic [7:0]  priority_req,
	input  logic [15:0] task_id,
	input  logic [5:0]  position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_task_id,
	output logic [7:0]  out_category,
	output logic [7:0]  out_priority,
	output logic [5:0]  match_position,
	output logic [1:0]  status,
	output logic        last
);

	localparam int AW = $clog2(DEPTH);

	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	otl_pkg::rec_t wdata;
	otl_pkg::rec_t rdata;
	logic          res_valid;
	logic          res_ready;
	otl_pkg::res_t res;
	otl_pkg::res_t out_res;

	// The records live in one synchronous memory, in list order from entry zero.
	otl_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// The sequencer appends, shifts records down after a remove, and scans for
	// matches. A search match is held back until the next match or the end of
	// the scan shows whether it is the final result.
	otl_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.category    (category),
		.priority_req(priority_req),
		.task_id     (task_id),
		.position    (position),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.raddr       (raddr),
		.rdata       (rdata),
		.res_valid   (res_valid),
		.res         (res),
		.res_ready   (res_ready)
	);

	// The output register decouples the consumer from the sequencer.
	otl_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(res_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

	assign out_task_id    = out_res.rec.task_id;
	assign out_category   = out_res.rec.category;
	assign out_priority   = out_res.rec.prio;
	assign match_position = out_res.pos;
	assign status         = out_res.status;
	assign last           = out_res.last;

endmodule

// File: rtl/core/otl_mem.sv
// Record store: one write port and one read port with registered read data.
module otl_mem #(
	parameter int DEPTH = otl_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  otl_pkg::rec_t              wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output otl_pkg::rec_t              rdata
);

	otl_pkg::rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/otl_ctrl.sv
// Sequencer: list count, append writes, remove shift pass and search scan.
module otl_ctrl #(
	parameter int DEPTH = otl_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 op,
	input  logic [7:0]                 category,
	input  logic [7:0]                 priority_req,
	input  logic [15:0]                task_id,
	input  logic [5:0]                 position,
	output logic                       we,
	output logic [$clog2(DEPTH)-1:0]   waddr,
	output otl_pkg::rec_t              wdata,
	output logic [$clog2(DEPTH)-1:0]   raddr,
	input  otl_pkg::rec_t              rdata,
	output logic                       res_valid,
	output otl_pkg::res_t              res,
	input  logic                       res_ready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (CW > otl_pkg::POS_W) ? CW : otl_pkg::POS_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]              state_q;
	logic [CW-1:0]           count_q;
	logic                    v_s1;
	logic                    pend_v_q;
	logic [CW-1:0]           idx_s1;
	logic [CW-1:0]           scan_q;
	logic [1:0]              mode_q;
	logic [7:0]              key_q;
	otl_pkg::rec_t           pend_q;
	logic [otl_pkg::POS_W-1:0] pend_pos_q;
	otl_pkg::res_t           fin_q;

	logic acc, full, pos_bad, is_rm, key_hit, match, need_push;
	logic consume, advance, more, scan_done;

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		acc       = in_valid && in_ready;
		full      = (count_q == CW'(DEPTH));
		pos_bad   = (position == '0) || (KW'(position) > KW'(count_q));
		is_rm     = (mode_q == otl_pkg::OP_REMOVE);
		key_hit   = (mode_q == otl_pkg::OP_CAT) ? (rdata.category == key_q)
		                                         : (rdata.prio == key_q);
		match     = !is_rm && v_s1 && key_hit;
		need_push = match && pend_v_q;
		consume   = v_s1 && (!need_push || res_ready);
		advance   = !v_s1 || consume;
		more      = (scan_q < count_q);
		scan_done = !v_s1 && !more;
		// A stalled entry is read again so the read data stays in place.
		raddr     = advance ? scan_q[AW-1:0] : idx_s1[AW-1:0];

		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = '{task_id: task_id, category: category, prio: priority_req};
		if (acc && (op == otl_pkg::OP_APPEND) && !full) begin
			we = 1'b1;
		end
		if ((state_q == S_SCAN) && is_rm && v_s1 && pend_v_q) begin
			// Shift each later record down by one place.
			we    = 1'b1;
			waddr = idx_s1[AW-1:0] - AW'(1);
			wdata = rdata;
		end

		res_valid = 1'b0;
		res       = fin_q;
		unique case (state_q)
			S_SCAN: begin
				res_valid = need_push;
				res       = '{rec: pend_q, pos: pend_pos_q, status: otl_pkg::ST_OK,
				              last: 1'b0};
			end
			S_FIN: begin
				res_valid = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			v_s1     <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						v_s1     <= 1'b0;
						pend_v_q <= 1'b0;
						unique case (op)
							otl_pkg::OP_APPEND: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_FIN;
							end
							otl_pkg::OP_REMOVE: begin
								state_q <= pos_bad ? S_FIN : S_SCAN;
							end
							default: begin
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (advance) begin
						v_s1 <= more;
					end
					if ((is_rm && v_s1) || (match && consume)) begin
						pend_v_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= S_FIN;
						if (is_rm) begin
							count_q <= count_q - CW'(1);
						end
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					mode_q     <= op;
					key_q      <= (op == otl_pkg::OP_CAT) ? category : priority_req;
					pend_pos_q <= position;
					scan_q     <= (op == otl_pkg::OP_REMOVE) ? CW'(position) - CW'(1)
					                                         : '0;
					fin_q      <= '{rec: '0, pos: '0,
					                status: (op == otl_pkg::OP_REMOVE) ? otl_pkg::ST_BADPOS
					                      : ((op == otl_pkg::OP_APPEND) && full)
					                        ? otl_pkg::ST_FULL : otl_pkg::ST_OK,
					                last: 1'b1};
				end
			end
			S_SCAN: begin
				if (advance && more) begin
					scan_q <= scan_q + CW'(1);
					idx_s1 <= scan_q;
				end
				if (is_rm && v_s1 && !pend_v_q) begin
					pend_q <= rdata;
				end
				if (match && consume) begin
					pend_q     <= rdata;
					pend_pos_q <= otl_pkg::POS_W'(idx_s1) + otl_pkg::POS_W'(1);
				end
				if (scan_done) begin
					if (is_rm || pend_v_q) begin
						fin_q <= '{rec: pend_q, pos: pend_pos_q, status: otl_pkg::ST_OK,
						           last: 1'b1};
					end else begin
						fin_q <= '{rec: '0, pos: '0, status: otl_pkg::ST_NOMATCH,
						           last: 1'b1};
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/otl_outbuf.sv
// Output register that holds one result item until the consumer takes it.
module otl_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  otl_pkg::res_t res,
	output logic          res_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output otl_pkg::res_t out_res
);

	logic          valid_q;
	otl_pkg::res_t data_q;

	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

endmodule

// File: sim/otl_checker.sv
// Checker for the ordered task list: mirrors the list and compares every result row.
module otl_checker #(
	parameter int DEPTH = otl_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  category,
	input  logic [7:0]  priority_req,
	input  logic [15:0] task_id,
	input  logic [5:0]  position,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] out_task_id,
	input  logic [7:0]  out_category,
	input  logic [7:0]  out_priority,
	input  logic [5:0]  match_position,
	input  logic [1:0]  status,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output int          list_len,
	output int          results_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import otl_pkg::*;

	rec_t stored [DEPTH];
	int   stored_len;
	res_t due_results [$];
	int   fails = 0;
	int   checked = 0;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		fails++;
		$display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
	endtask

	// Updates the mirrored list for one accepted item and queues the rows it must produce.
	task automatic step_list(input logic [1:0] opc, input logic [7:0] cat,
			input logic [7:0] pri, input logic [15:0] tid, input logic [5:0] pos);
		res_t       row;
		int         i;
		int         final_hit;
		logic [7:0] key;
		logic [7:0] field;
		row = '0;
		row.last = 1'b1;
		case (opc)
			OP_APPEND: begin
				if (stored_len >= DEPTH) begin
					row.status = ST_FULL;
				end else begin
					stored[stored_len].task_id = tid;
					stored[stored_len].category = cat;
					stored[stored_len].prio = pri;
					stored_len++;
					row.status = ST_OK;
				end
				due_results.push_back(row);
			end
			OP_REMOVE: begin
				if (pos == 0 || int'(pos) > stored_len) begin
					row.status = ST_BADPOS;
				end else begin
					row.rec = stored[int'(pos) - 1];
					row.pos = pos;
					row.status = ST_OK;
					for (i = int'(pos) - 1; i < stored_len - 1; i++) begin
						stored[i] = stored[i + 1];
					end
					stored_len--;
				end
				due_results.push_back(row);
			end
			default: begin
				key = (opc == OP_CAT) ? cat : pri;
				final_hit = -1;
				for (i = 0; i < stored_len; i++) begin
					field = (opc == OP_CAT) ? stored[i].category : stored[i].prio;
					if (field == key) final_hit = i;
				end
				if (final_hit < 0) begin
					row.status = ST_NOMATCH;
					due_results.push_back(row);
				end else begin
					for (i = 0; i <= final_hit; i++) begin
						field = (opc == OP_CAT) ? stored[i].category : stored[i].prio;
						if (field == key) begin
							row.rec = stored[i];
							row.pos = 6'(i + 1);
							row.status = ST_OK;
							row.last = (i == final_hit);
							due_results.push_back(row);
						end
					end
				end
			end
		endcase
	endtask

	task automatic check_result();
		res_t want;
		if (due_results.size() == 0) begin
			report_mismatch("unexpected result, task id", out_task_id, 16'h0);
		end else begin
			want = due_results.pop_front();
			checked++;
			if (out_task_id !== want.rec.task_id)
				report_mismatch("task id", out_task_id, want.rec.task_id);
			if (out_category !== want.rec.category)
				report_mismatch("category", 16'(out_category), 16'(want.rec.category));
			if (out_priority !== want.rec.prio)
				report_mismatch("priority", 16'(out_priority), 16'(want.rec.prio));
			if (match_position !== want.pos)
				report_mismatch("position", 16'(match_position), 16'(want.pos));
			if (status !== want.status)
				report_mismatch("status", 16'(status), 16'(want.status));
			if (last !== want.last)
				report_mismatch("last", 16'(last), 16'(want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_len = 0;
			due_results.delete();
			fail_count <= 0;
			pending <= 0;
			list_len <= 0;
			results_checked <= 0;
		end else begin
			if (out_valid && out_ready) check_result();
			if (in_valid && in_ready) step_list(op, category, priority_req, task_id, position);
			fail_count <= fails;
			pending <= due_results.size();
			list_len <= stored_len;
			results_checked <= checked;
		end
	end

endmodule

// File: sim/tb_ordered_task_list.sv
// Testbench top for the ordered task list: clock, reset, stimulus and verdict.
module tb_ordered_task_list;
	timeunit 1ns;
	timeprecision 1ps;
	import otl_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;
	// Far beyond the slowest correct run: every item a full-length search with the
	// receiver stalling, plus sender gaps.
	localparam int TIMEOUT_NS = 5_000_000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  category;
	logic [7:0]  priority_req;
	logic [15:0] task_id;
	logic [5:0]  position;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] out_task_id;
	logic [7:0]  out_category;
	logic [7:0]  out_priority;
	logic [5:0]  match_position;
	logic [1:0]  status;
	logic        last;

	int fail_count;
	int pending;
	int list_len;
	int results_checked;

	// While calm is set neither side idles, giving one long stretch at full rate.
	bit calm = 1'b0;
	int appends = 0;
	int removes = 0;
	int searches = 0;
	int full_appends = 0;

	always #4 clk = ~clk;

	ordered_task_list DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.category(category),
		.priority_req(priority_req),
		.task_id(task_id),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_task_id(out_task_id),
		.out_category(out_category),
		.out_priority(out_priority),
		.match_position(match_position),
		.status(status),
		.last(last)
	);

	otl_checker #(.DEPTH(LIST_DEPTH)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.category(category),
		.priority_req(priority_req),
		.task_id(task_id),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_task_id(out_task_id),
		.out_category(out_category),
		.out_priority(out_priority),
		.match_position(match_position),
		.status(status),
		.last(last),
		.fail_count(fail_count),
		.pending(pending),
		.list_len(list_len),
		.results_checked(results_checked)
	);

	// The receiver stalls with a chance of about 13 in a hundred, decided fresh every cycle so
	// that stalls land in the middle of search scans as well as on single results.
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 13);
	end

	// Idles the sender for a random number of cycles and returns at the falling edge on
	// which the next item is to be driven. Each falling edge sees a single assignment
	// to in_valid, so a valid that stays high between items is never dropped and raised.
	task automatic wait_slot();
		while (!calm && $urandom_range(99) < 13) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
	endtask

	// Drives one item and holds it until the block takes it. Must be called right after
	// wait_slot, at a falling edge.
	task automatic drive_item(input logic [1:0] opc, input logic [7:0] cat,
			input logic [7:0] pri, input logic [15:0] tid, input logic [5:0] pos);
		case (opc)
			OP_APPEND: begin
				appends++;
				if (list_len >= LIST_DEPTH) full_appends++;
			end
			OP_REMOVE: removes++;
			default: searches++;
		endcase
		in_valid <= 1'b1;
		op <= opc;
		category <= cat;
		priority_req <= pri;
		task_id <= tid;
		position <= pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_item(input logic [1:0] opc, input logic [7:0] cat,
			input logic [7:0] pri, input logic [15:0] tid, input logic [5:0] pos);
		wait_slot();
		drive_item(opc, cat, pri, tid, pos);
	endtask

	// Keys come mostly from a small pool so that searches hit several records at once;
	// the pool values together set and clear every bit.
	function automatic logic [7:0] pick_key();
		case ($urandom_range(9))
			0, 1: return 8'h00;
			2, 3: return 8'hFF;
			4:    return 8'h5A;
			5, 6: return 8'hA5;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly a position that exists in the list, sometimes zero or one past the tail,
	// and now and then anything from zero up to the list depth.
	function automatic logic [5:0] pick_position();
		int roll;
		roll = $urandom_range(99);
		if (list_len > 0 && roll < 80) return 6'($urandom_range(list_len, 1));
		if (roll < 88) return 6'd0;
		if (roll < 94 && list_len < LIST_DEPTH) return 6'(list_len + 1);
		return 6'($urandom_range(LIST_DEPTH, 0));
	endfunction

	// One random item. grow_pct is the share of appends; the rest splits evenly between
	// removes and the two kinds of search, so the list drifts up or down per phase.
	task automatic random_item(input int grow_pct);
		int         roll;
		logic [1:0] opc;
		wait_slot();
		roll = $urandom_range(99);
		if (roll < grow_pct) begin
			opc = OP_APPEND;
		end else if (roll < grow_pct + (100 - grow_pct) / 2) begin
			opc = OP_REMOVE;
		end else begin
			opc = $urandom_range(1) ? OP_CAT : OP_PRIO;
		end
		drive_item(opc, pick_key(), pick_key(), 16'($urandom), pick_position());
	endtask

	// Appends random records until the list is full, then one more append that must be
	// refused. The decision uses the length as it stands at the falling edge.
	task automatic fill_list();
		bit was_full;
		do begin
			wait_slot();
			was_full = (list_len >= LIST_DEPTH);
			drive_item(OP_APPEND, pick_key(), pick_key(), 16'($urandom), 6'd0);
		end while (!was_full);
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int ph;
		int n;
		int grow_plan [7];
		grow_plan = '{65, 20, 45, 70, 15, 50, 40};

		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_APPEND;
		category = 8'h00;
		priority_req = 8'h00;
		task_id = 16'h0000;
		position = 6'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Searches and removes on the empty list come first.
		send_item(OP_CAT, 8'h00, 8'h00, 16'h0000, 6'd0);
		send_item(OP_PRIO, 8'h00, 8'hFF, 16'h0000, 6'd0);
		send_item(OP_REMOVE, 8'h00, 8'h00, 16'h0000, 6'd0);
		send_item(OP_REMOVE, 8'h00, 8'h00, 16'h0000, 6'd1);
		// Records with the field extremes, sharing keys so searches return several rows.
		send_item(OP_APPEND, 8'h00, 8'hFF, 16'h0000, 6'd0);
		send_item(OP_APPEND, 8'hFF, 8'h00, 16'hFFFF, 6'd0);
		send_item(OP_APPEND, 8'h00, 8'h00, 16'h1234, 6'd0);
		send_item(OP_APPEND, 8'h5A, 8'hFF, 16'hA5A5, 6'd0);
		send_item(OP_APPEND, 8'h00, 8'h5A, 16'h5A5A, 6'd0);
		send_item(OP_CAT, 8'h00, 8'h11, 16'h0000, 6'd0);
		send_item(OP_PRIO, 8'h22, 8'hFF, 16'h0000, 6'd0);
		send_item(OP_CAT, 8'h77, 8'h00, 16'h0000, 6'd0);
		send_item(OP_PRIO, 8'hFF, 8'h00, 16'h0000, 6'd0);
		// A zero position and one just past the tail are both rejected.
		send_item(OP_REMOVE, 8'h00, 8'h00, 16'h0000, 6'd0);
		send_item(OP_REMOVE, 8'h00, 8'h00, 16'h0000, 6'd6);
		// Take out the tail, the head and then a middle record.
		send_item(OP_REMOVE, 8'h00, 8'h00, 16'h0000, 6'd5);
		send_item(OP_REMOVE, 8'h00, 8'h00, 16'h0000, 6'd1);
		send_item(OP_REMOVE, 8'h00, 8'h00, 16'h0000, 6'd2);
		send_item(OP_CAT, 8'hFF, 8'h00, 16'h0000, 6'd0);
		send_item(OP_REMOVE, 8'h00, 8'h00, 16'h0000, 6'd2);
		send_item(OP_REMOVE, 8'h00, 8'h00, 16'h0000, 6'd1);
		// The list has been emptied again; a search must report no match.
		send_item(OP_PRIO, 8'h00, 8'h00, 16'h0000, 6'd0);
		send_item(OP_APPEND, 8'h80, 8'h01, 16'h8001, 6'd0);

		// Fill to capacity, search the full list, remove the very last position and
		// refill so that the refused append is seen twice.
		fill_list();
		send_item(OP_CAT, pick_key(), 8'h00, 16'h0000, 6'd0);
		send_item(OP_PRIO, 8'h00, pick_key(), 16'h0000, 6'd0);
		send_item(OP_REMOVE, 8'h00, 8'h00, 16'h0000, 6'(LIST_DEPTH));
		fill_list();
		send_item(OP_REMOVE, 8'h00, 8'h00, 16'h0000, 6'd1);

		// Random phases vary the mix of growing and shrinking the list. The fourth
		// phase runs with no idling on either side.
		for (ph = 0; ph < 7; ph++) begin
			calm = (ph == 3);
			for (n = 0; n < 50; n++) begin
				random_item(grow_plan[ph]);
			end
		end
		calm = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;

		// Every item produces at least one result, so an empty expectation queue means
		// the block is idle; the extra wait catches any stray results.
		while (pending != 0) @(posedge clk);
		repeat (48) @(posedge clk);

		$display("Sent %0d items: %0d appends (%0d onto a full list), %0d removes, %0d searches.",
			appends + removes + searches, appends, full_appends, removes, searches);
		$display("Checked %0d result rows, %0d mismatches.", results_checked, fail_count);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
